// ----- rtl/stop_and_wait_sender_loss_window_defines.svh -----
// Assertion macros for the stop-and-wait sender.
// Included by the top level only; expects clk and rst in scope.
`ifndef STOP_AND_WAIT_SENDER_LOSS_WINDOW_DEFINES_SVH
`define STOP_AND_WAIT_SENDER_LOSS_WINDOW_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/swsl_pkg.sv -----
// Types and constants for the stop-and-wait sender with a loss window.
// No dependencies.
package swsl_pkg;

  typedef enum logic [1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_WAIT      = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_ABANDONED = 3'd2,
    ST_FAILED    = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef enum logic {
    REG_THRESHOLD  = 1'b0,
    REG_RESEND_CAP = 1'b1
  } reg_idx_t;

  localparam int          THR_W         = 7;
  localparam int          RETRY_W       = 8;
  localparam int          LOSS_CNT_W    = 5;
  // Wide enough for 16 losses * 100 and 127 * 16 window slots.
  localparam int          CMP_W         = 12;
  localparam logic [CMP_W-1:0] PCT_SCALE = 12'd100;
  localparam logic [THR_W-1:0]   THR_RESET   = 7'd10;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd100;

endpackage

// ----- rtl/stop_and_wait_sender_loss_window.sv -----
// Stop-and-wait sender, alternating sequence bit, partial reliability over a loss window.
// Uses swsl_pkg and stop_and_wait_sender_loss_window_defines.svh.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | func, ack_flag, ack_number
//   out     | output    | out_valid / out_stall| transmit, seq_bit, status, loss_count
//   cfg     | input     | APB psel / penable   | paddr, pwdata, prdata
//
// One transaction per cycle sustained while the output is not stalled. An event
// waits in the input register and its result is then loaded into the result register.
// The sender state advances as an event leaves the input register.
// rst is synchronous; it clears the sender state and restores register defaults.
// in_stall rises only while the input register is full and the result is held.
`include "stop_and_wait_sender_loss_window_defines.svh"

module stop_and_wait_sender_loss_window #(
  parameter int WINDOW_SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic        ack_flag,
  input  logic        ack_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        transmit,
  output logic        seq_bit,
  output logic [2:0]  status,
  output logic [4:0]  loss_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [swsl_pkg::CMP_W-1:0] WIN_SCALE =
    swsl_pkg::CMP_W'(WINDOW_SLOTS);

  // Configuration
  logic [swsl_pkg::THR_W-1:0]   loss_threshold_percent;
  logic [swsl_pkg::RETRY_W-1:0] resend_cap;
  swsl_pkg::reg_idx_t           reg_sel;
  logic                         cfg_write;

  // Input register
  logic                  s1_valid;
  swsl_pkg::func_t       s1_func;
  logic                  s1_ack_flag;
  logic                  s1_ack_number;
  logic                  in_accept;
  logic                  s1_move;

  // Sender state
  logic                        next_seq, next_seq_next;
  logic [WINDOW_SLOTS-1:0]     loss_marks, loss_marks_next;
  logic [SLOT_W-1:0]           slot_index, slot_index_next;
  logic [swsl_pkg::RETRY_W-1:0] resend_count, resend_count_next;
  logic                        awaiting_ack, awaiting_ack_next;

  logic                   transmit_next;
  swsl_pkg::status_t      status_next;
  logic [CNT_W-1:0]       count_next;
  logic [WINDOW_SLOTS-1:0] marks_lost;
  logic [CNT_W-1:0]       count_lost;
  logic                   good_ack;
  logic [swsl_pkg::CMP_W-1:0] loss_scaled;
  logic [swsl_pkg::CMP_W-1:0] thr_scaled;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign reg_sel   = swsl_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_threshold_percent <= swsl_pkg::THR_RESET;
      resend_cap             <= swsl_pkg::RETRY_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        swsl_pkg::REG_THRESHOLD:  loss_threshold_percent <= pwdata[swsl_pkg::THR_W-1:0];
        swsl_pkg::REG_RESEND_CAP: resend_cap             <= pwdata[swsl_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swsl_pkg::REG_THRESHOLD:  prdata = 32'(loss_threshold_percent);
      swsl_pkg::REG_RESEND_CAP: prdata = 32'(resend_cap);
      default:                  prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- handshake
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_accept || (s1_valid && !s1_move);
      out_valid <= s1_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func       <= swsl_pkg::func_t'(func);
      s1_ack_flag   <= ack_flag;
      s1_ack_number <= ack_number;
    end
  end

  // ------------------------------------------------------------ decision
  assign good_ack = (s1_func == swsl_pkg::FUNC_ACK) && s1_ack_flag &&
                    (s1_ack_number == !next_seq);

  // Losses in the window once the current slot is marked lost
  always_comb begin
    marks_lost             = loss_marks;
    marks_lost[slot_index] = 1'b1;
    count_lost             = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      count_lost = count_lost + CNT_W'(marks_lost[i]);
    end
  end

  // floor(losses*100/W) < thr is the same test as losses*100 < thr*W
  assign loss_scaled = swsl_pkg::CMP_W'(count_lost) * swsl_pkg::PCT_SCALE;
  assign thr_scaled  = swsl_pkg::CMP_W'(loss_threshold_percent) * WIN_SCALE;

  always_comb begin
    next_seq_next     = next_seq;
    loss_marks_next   = loss_marks;
    slot_index_next   = slot_index;
    resend_count_next = resend_count;
    awaiting_ack_next = awaiting_ack;
    transmit_next     = 1'b0;
    status_next       = swsl_pkg::ST_IGNORED;

    case (s1_func)
      swsl_pkg::FUNC_SEND: begin
        if (!awaiting_ack) begin
          slot_index_next   = (slot_index == LAST_SLOT) ? '0 : slot_index + 1'b1;
          awaiting_ack_next = 1'b1;
          resend_count_next = '0;
          transmit_next     = 1'b1;
          status_next       = swsl_pkg::ST_WAIT;
        end
      end
      swsl_pkg::FUNC_ACK, swsl_pkg::FUNC_TIMEOUT: begin
        if (awaiting_ack) begin
          if (good_ack) begin
            next_seq_next               = !next_seq;
            loss_marks_next[slot_index] = 1'b0;
            awaiting_ack_next           = 1'b0;
            status_next                 = swsl_pkg::ST_DELIVERED;
          end else begin
            loss_marks_next[slot_index] = 1'b1;
            if (loss_scaled < thr_scaled) begin
              awaiting_ack_next = 1'b0;
              status_next       = swsl_pkg::ST_ABANDONED;
            end else if (resend_count >= resend_cap) begin
              awaiting_ack_next = 1'b0;
              status_next       = swsl_pkg::ST_FAILED;
            end else begin
              resend_count_next = resend_count + 1'b1;
              transmit_next     = 1'b1;
              status_next       = swsl_pkg::ST_WAIT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Count losses in the window after this event's mark update
  always_comb begin
    count_next = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      count_next = count_next + CNT_W'(loss_marks_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq     <= 1'b0;
      loss_marks   <= '0;
      slot_index   <= '0;
      resend_count <= '0;
      awaiting_ack <= 1'b0;
    end else if (s1_move) begin
      next_seq     <= next_seq_next;
      loss_marks   <= loss_marks_next;
      slot_index   <= slot_index_next;
      resend_count <= resend_count_next;
      awaiting_ack <= awaiting_ack_next;
    end
  end

  // Result register: load as the event leaves the input register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      transmit   <= transmit_next;
      seq_bit    <= next_seq_next;
      status     <= status_next;
      loss_count <= swsl_pkg::LOSS_CNT_W'(count_next);
    end
  end

  // ------------------------------------------------------------- checks
  `SWSL_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid, "input stalled with empty register")
  `SWSL_ASSERT_NOW(a_tx_only_waiting, out_valid && transmit,
                   status == swsl_pkg::ST_WAIT, "transmit without waiting status")
  `SWSL_ASSERT_NOW(a_count_in_window, out_valid,
                   loss_count <= 5'(WINDOW_SLOTS), "loss count exceeds window")
  `SWSL_ASSERT_NEXT(a_delivered_toggles, s1_move && status_next == swsl_pkg::ST_DELIVERED,
                    seq_bit != $past(next_seq), "delivery did not toggle sequence bit")

endmodule
